// ----- hw/rtl/quaternion_slerp_top_assert.svh -----
// assertion macros for the slerp checker
`ifndef QUATERNION_SLERP_TOP_ASSERT_SVH
`define QUATERNION_SLERP_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define QS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/qs_pkg.sv -----
// shared constants, tables and types for the quaternion slerp pipeline
package qs_pkg;
	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_MAX   = 32;
	localparam int T_ONE        = 65536;
	localparam int QUARTER_TURN = 1 << 30;
	localparam int ROT_SEED     = 1 << 20;
	localparam logic [14:0] THR_RESET = 15'd16376;

	localparam int VEC_W  = 33;   // vectoring x/y
	localparam int ROT_W  = 24;   // rotation x/y
	localparam int ANG_W  = 33;   // angle accumulators
	localparam int SQA_W  = 61;   // radicand 2^60 - c*c
	localparam int SQB_W  = 62;   // sum of squares
	localparam int NORM_W = 31;
	localparam int NUM_W  = 46;
	localparam int QUO_W  = 16;

	localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// first quaternion, blend and path select
	typedef struct packed {
		logic [3:0][15:0] a;
		logic [16:0]      t;
		logic             near;
	} qs_lane_a_t;

	// second quaternion after the shorter-arc sign flip
	typedef struct packed {
		logic [3:0][16:0] b;
	} qs_lane_b_t;

	typedef struct packed {
		qs_lane_a_t la;
		qs_lane_b_t lb;
	} qs_ctx_t;

	typedef struct packed {
		logic [3:0] neg;
		logic       zero;
	} qs_div_side_t;
endpackage

// ----- hw/rtl/qs_sqrt_cell.sv -----
// one digit step of the pipelined integer square root
module qs_sqrt_cell #(
	parameter int W  = 62,
	parameter int K  = 0,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  x_i,
	input  logic [W-1:0]  r_i,
	input  logic [SW-1:0] side_i,
	output logic [W-1:0]  x_o,
	output logic [W-1:0]  r_o,
	output logic [SW-1:0] side_o
);
	localparam logic [W:0] BIT = (W+1)'(1) << (2 * K);

	logic [W:0] trial;
	logic       fits;

	assign trial = {1'b0, r_i} + BIT;
	assign fits  = {1'b0, x_i} >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			if (fits) begin
				x_o <= x_i - trial[W-1:0];
				r_o <= (r_i >> 1) + BIT[W-1:0];
			end else begin
				x_o <= x_i;
				r_o <= r_i >> 1;
			end
		end
	end
endmodule

// ----- hw/rtl/qs_cordic_cell.sv -----
// one micro-rotation of a pipelined cordic, vectoring or rotation mode
module qs_cordic_cell #(
	parameter int XW        = 33,
	parameter int ZW        = 33,
	parameter int I         = 0,
	parameter bit VECTORING = 1'b1,
	parameter int SW        = 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [XW-1:0] x_i,
	input  logic signed [XW-1:0] y_i,
	input  logic signed [ZW-1:0] z_i,
	input  logic [SW-1:0]        side_i,
	output logic signed [XW-1:0] x_o,
	output logic signed [XW-1:0] y_o,
	output logic signed [ZW-1:0] z_o,
	output logic [SW-1:0]        side_o
);
	import qs_pkg::*;

	localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[I]);

	logic signed [XW-1:0] dx, dy;
	logic                 up;

	assign dx = y_i >>> I;
	assign dy = x_i >>> I;
	// vectoring drives y to zero, rotation drives z to zero
	assign up = VECTORING ? !y_i[XW-1] : z_i[ZW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			if (up) begin
				x_o <= x_i + dx;
				y_o <= y_i - dy;
				z_o <= z_i + ANG;
			end else begin
				x_o <= x_i - dx;
				y_o <= y_i + dy;
				z_o <= z_i - ANG;
			end
		end
	end
endmodule

// ----- hw/rtl/qs_div_cell.sv -----
// one quotient bit of the four-lane restoring divider
module qs_div_cell #(
	parameter int NW = 46,
	parameter int DW = 31,
	parameter int QW = 16,
	parameter int K  = 0,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                en,
	input  logic [3:0][NW-1:0]  rem_i,
	input  logic [3:0][QW-1:0]  q_i,
	input  logic [DW-1:0]       den_i,
	input  logic [SW-1:0]       side_i,
	output logic [3:0][NW-1:0]  rem_o,
	output logic [3:0][QW-1:0]  q_o,
	output logic [DW-1:0]       den_o,
	output logic [SW-1:0]       side_o
);
	localparam logic [QW-1:0] QBIT = QW'(1) << K;

	logic [NW-1:0] dsh;

	assign dsh = NW'(den_i) << K;

	always_ff @(posedge clk) begin
		if (en) begin
			den_o  <= den_i;
			side_o <= side_i;
			for (int i = 0; i < 4; i++) begin
				if (rem_i[i] >= dsh) begin
					rem_o[i] <= rem_i[i] - dsh;
					q_o[i]   <= q_i[i] | QBIT;
				end else begin
					rem_o[i] <= rem_i[i];
					q_o[i]   <= q_i[i];
				end
			end
		end
	end
endmodule

// ----- hw/rtl/quaternion_slerp_top.sv -----
// quaternion slerp: dot, sqrt, atan, sine weights, blend, normalize
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   cfg      | cfg_valid / cfg_ready  | cfg_data = near_threshold
//   in       | in_valid / in_stall    | a_w..a_z, b_w..b_z, blend
//   out      | out_valid / out_stall  | out_w..out_z
//
// one request per cycle while the stages advance; each request runs through
// the two 31-step square roots, the vectoring and rotation cordic chains,
// the 16-step divider and finally the output register.
// all stages move together; they hold only while the output is full and
// stalled and the last stage holds a request. reset clears the valids and
// loads the default threshold; datapath registers are not reset.
module quaternion_slerp_top #(
	parameter int CORDIC_STEPS = qs_pkg::CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] a_w,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] b_w,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	input  logic [16:0]        blend,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_w,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z
);
	import qs_pkg::*;

	localparam int N      = CORDIC_STEPS;
	localparam int SQA_N  = (SQA_W - 1) / 2 + 1;
	localparam int SQB_N  = (SQB_W - 1) / 2 + 1;
	localparam int CTX_W  = $bits(qs_ctx_t);
	localparam int LA_W   = $bits(qs_lane_a_t);
	localparam int LB_W   = $bits(qs_lane_b_t);
	localparam int DS_W   = $bits(qs_div_side_t);
	localparam int CSH    = 30 - 2 * FRAC_BITS;
	localparam int L      = 4 + SQA_N + 2 * N + 1 + 5 + SQB_N + 1 + QUO_W;

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		if (v > 17'sd32767)
			return 16'sh7FFF;
		else if (v < -17'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// handshake and config
	logic          out_vld_q, out_take, adv;
	logic [L-1:0]  vld_q;
	logic [14:0]   near_threshold_q;

	assign cfg_ready = 1'b1;
	assign out_take  = !out_vld_q || !out_stall;
	assign adv       = out_take || !vld_q[L-1];
	assign in_stall  = !adv;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_threshold_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			near_threshold_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv)
				vld_q <= {vld_q[L-2:0], in_valid};
			if (out_take)
				out_vld_q <= vld_q[L-1];
		end
	end

	// s1: register inputs, clamp the blend, partial products of the dot
	logic signed [15:0] a_in [4];
	logic signed [15:0] b_in [4];
	logic signed [15:0] a_s1 [4];
	logic signed [15:0] b_s1 [4];
	logic signed [31:0] prod_s1 [4];
	logic [16:0]        t_s1;

	assign a_in = '{a_w, a_x, a_y, a_z};
	assign b_in = '{b_w, b_x, b_y, b_z};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				a_s1[i]    <= a_in[i];
				b_s1[i]    <= b_in[i];
				prod_s1[i] <= a_in[i] * b_in[i];
			end
			t_s1 <= (blend > 17'(T_ONE)) ? 17'(T_ONE) : blend;
		end
	end

	// s2: dot product
	logic signed [15:0] a_s2 [4];
	logic signed [15:0] b_s2 [4];
	logic signed [33:0] dot_s2;
	logic [16:0]        t_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			t_s2   <= t_s1;
			dot_s2 <= 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2])
				+ 34'(prod_s1[3]);
		end
	end

	// s3: shorter arc, path select, cosine in q.30
	logic        neg3;
	logic [32:0] dabs;
	logic [34:0] c_full;
	qs_ctx_t     ctx3, ctx_s3;
	logic [30:0] c_s3;

	assign neg3   = dot_s2[33];
	assign dabs   = 33'(neg3 ? -dot_s2 : dot_s2);
	assign c_full = 35'(dabs) << CSH;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ctx3.la.a[i] = a_s2[i];
			ctx3.lb.b[i] = neg3 ? -17'(b_s2[i]) : 17'(b_s2[i]);
		end
		ctx3.la.t    = t_s2;
		ctx3.la.near = dabs > (33'(near_threshold_q) << FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx3;
			c_s3   <= (c_full > 35'(QUARTER_TURN)) ? 31'(QUARTER_TURN) : c_full[30:0];
		end
	end

	// s4: radicand for the sine of the angle
	logic [61:0]      csq;
	logic [SQA_W-1:0] rad_s4;
	qs_ctx_t          ctx_s4;
	logic [30:0]      c_s4;

	assign csq = 62'(c_s3) * 62'(c_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s4 <= SQA_W'((62'(1) << 60) - csq);
			ctx_s4 <= ctx_s3;
			c_s4   <= c_s3;
		end
	end

	// square root chain: s = sqrt(1 - c^2)
	logic [SQA_W-1:0]    sa_x    [SQA_N+1];
	logic [SQA_W-1:0]    sa_r    [SQA_N+1];
	logic [CTX_W+30:0]   sa_side [SQA_N+1];

	assign sa_x[0]    = rad_s4;
	assign sa_r[0]    = '0;
	assign sa_side[0] = {ctx_s4, c_s4};

	for (genvar k = 0; k < SQA_N; k++) begin : g_sqa
		qs_sqrt_cell #(.W(SQA_W), .K(SQA_N - 1 - k), .SW(CTX_W + 31)) u_cell (
			.clk    (clk),
			.en     (adv),
			.x_i    (sa_x[k]),
			.r_i    (sa_r[k]),
			.side_i (sa_side[k]),
			.x_o    (sa_x[k+1]),
			.r_o    (sa_r[k+1]),
			.side_o (sa_side[k+1])
		);
	end

	// vectoring cordic: theta = atan2(s, c)
	logic signed [VEC_W-1:0] vx [N+1];
	logic signed [VEC_W-1:0] vy [N+1];
	logic signed [ANG_W-1:0] vz [N+1];
	logic [CTX_W-1:0]        vside [N+1];

	assign vx[0]    = VEC_W'(sa_side[SQA_N][30:0]);
	assign vy[0]    = VEC_W'(sa_r[SQA_N][30:0]);
	assign vz[0]    = '0;
	assign vside[0] = sa_side[SQA_N][CTX_W+30:31];

	for (genvar k = 0; k < N; k++) begin : g_vec
		qs_cordic_cell #(.XW(VEC_W), .ZW(ANG_W), .I(k), .VECTORING(1'b1), .SW(CTX_W)) u_cell (
			.clk    (clk),
			.en     (adv),
			.x_i    (vx[k]),
			.y_i    (vy[k]),
			.z_i    (vz[k]),
			.side_i (vside[k]),
			.x_o    (vx[k+1]),
			.y_o    (vy[k+1]),
			.z_o    (vz[k+1]),
			.side_o (vside[k+1])
		);
	end

	// s5: split the angle by t
	qs_ctx_t     ctx5, ctx_s5;
	logic [30:0] theta;
	logic [47:0] m1, m2;
	logic [30:0] phi1_s5, phi2_s5;

	assign ctx5  = qs_ctx_t'(vside[N]);
	assign theta = vz[N][ANG_W-1] ? '0 :
		(vz[N] > ANG_W'(QUARTER_TURN)) ? 31'(QUARTER_TURN) : vz[N][30:0];
	assign m1 = 48'(theta) * 48'(17'(T_ONE) - ctx5.la.t);
	assign m2 = 48'(theta) * 48'(ctx5.la.t);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5  <= ctx5;
			phi1_s5 <= m1[46:16];
			phi2_s5 <= m2[46:16];
		end
	end

	// rotation cordic, two lanes: sin(phi1) and sin(phi2)
	logic signed [ROT_W-1:0] rxa [N+1];
	logic signed [ROT_W-1:0] rya [N+1];
	logic signed [ANG_W-1:0] rza [N+1];
	logic [LA_W-1:0]         rsa [N+1];
	logic signed [ROT_W-1:0] rxb [N+1];
	logic signed [ROT_W-1:0] ryb [N+1];
	logic signed [ANG_W-1:0] rzb [N+1];
	logic [LB_W-1:0]         rsb [N+1];

	assign rxa[0] = ROT_W'(ROT_SEED);
	assign rya[0] = '0;
	assign rza[0] = ANG_W'(phi1_s5);
	assign rsa[0] = ctx_s5.la;
	assign rxb[0] = ROT_W'(ROT_SEED);
	assign ryb[0] = '0;
	assign rzb[0] = ANG_W'(phi2_s5);
	assign rsb[0] = ctx_s5.lb;

	for (genvar k = 0; k < N; k++) begin : g_rot
		qs_cordic_cell #(.XW(ROT_W), .ZW(ANG_W), .I(k), .VECTORING(1'b0), .SW(LA_W)) u_lane_a (
			.clk    (clk),
			.en     (adv),
			.x_i    (rxa[k]),
			.y_i    (rya[k]),
			.z_i    (rza[k]),
			.side_i (rsa[k]),
			.x_o    (rxa[k+1]),
			.y_o    (rya[k+1]),
			.z_o    (rza[k+1]),
			.side_o (rsa[k+1])
		);
		qs_cordic_cell #(.XW(ROT_W), .ZW(ANG_W), .I(k), .VECTORING(1'b0), .SW(LB_W)) u_lane_b (
			.clk    (clk),
			.en     (adv),
			.x_i    (rxb[k]),
			.y_i    (ryb[k]),
			.z_i    (rzb[k]),
			.side_i (rsb[k]),
			.x_o    (rxb[k+1]),
			.y_o    (ryb[k+1]),
			.z_o    (rzb[k+1]),
			.side_o (rsb[k+1])
		);
	end

	// s6: pick sine or linear weights
	qs_lane_a_t         la6;
	qs_lane_b_t         lb6;
	logic signed [18:0] sin1, sin2;
	logic               use_lin;
	logic signed [18:0] wa_s6, wb_s6;
	logic [3:0][15:0]   a_s6;
	logic [3:0][16:0]   b_s6;

	assign la6     = qs_lane_a_t'(rsa[N]);
	assign lb6     = qs_lane_b_t'(rsb[N]);
	assign sin1    = rya[N][ROT_W-1:5];
	assign sin2    = ryb[N][ROT_W-1:5];
	assign use_lin = la6.near || (sin1 == '0 && sin2 == '0);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s6  <= la6.a;
			b_s6  <= lb6.b;
			wa_s6 <= use_lin ? 19'(17'(T_ONE) - la6.t) : sin1;
			wb_s6 <= use_lin ? 19'(la6.t) : sin2;
		end
	end

	// s7: weighted terms
	logic signed [34:0] pa_s7 [4];
	logic signed [35:0] pb_s7 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				pa_s7[i] <= wa_s6 * $signed(a_s6[i]);
				pb_s7[i] <= wb_s6 * $signed(b_s6[i]);
			end
		end
	end

	// s8: blended components, floor-shifted by two
	logic signed [36:0] bsum [4];
	logic [3:0][31:0]   v_s8;

	always_comb begin
		for (int i = 0; i < 4; i++)
			bsum[i] = 37'(pa_s7[i]) + 37'(pb_s7[i]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++)
				v_s8[i] <= bsum[i][33:2];
		end
	end

	// s9: squares
	logic [59:0]      sq_s9 [4];
	logic [3:0][31:0] v_s9;
	logic [63:0]      sqp [4];

	always_comb begin
		for (int i = 0; i < 4; i++)
			sqp[i] = 64'($signed(v_s8[i]) * $signed(v_s8[i]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s9 <= v_s8;
			for (int i = 0; i < 4; i++)
				sq_s9[i] <= sqp[i][59:0];
		end
	end

	// s10: sum of squares
	logic [SQB_W-1:0] ss_s10;
	logic [3:0][31:0] v_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s10  <= v_s9;
			ss_s10 <= SQB_W'(sq_s9[0]) + SQB_W'(sq_s9[1]) + SQB_W'(sq_s9[2])
				+ SQB_W'(sq_s9[3]);
		end
	end

	// square root chain: norm
	logic [SQB_W-1:0] sb_x    [SQB_N+1];
	logic [SQB_W-1:0] sb_r    [SQB_N+1];
	logic [127:0]     sb_side [SQB_N+1];

	assign sb_x[0]    = ss_s10;
	assign sb_r[0]    = '0;
	assign sb_side[0] = v_s10;

	for (genvar k = 0; k < SQB_N; k++) begin : g_sqb
		qs_sqrt_cell #(.W(SQB_W), .K(SQB_N - 1 - k), .SW(128)) u_cell (
			.clk    (clk),
			.en     (adv),
			.x_i    (sb_x[k]),
			.r_i    (sb_r[k]),
			.side_i (sb_side[k]),
			.x_o    (sb_x[k+1]),
			.r_o    (sb_r[k+1]),
			.side_o (sb_side[k+1])
		);
	end

	// s11: magnitudes scaled up, plus half the norm for rounding
	logic [NORM_W-1:0]          norm11;
	logic [3:0][31:0]           v11;
	logic [30:0]                mag11 [4];
	logic [3:0][NUM_W-1:0]      num_s11;
	logic [NORM_W-1:0]          norm_s11;
	qs_div_side_t               ds11, ds_s11;

	assign norm11 = sb_r[SQB_N][NORM_W-1:0];
	assign v11    = sb_side[SQB_N];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ds11.neg[i] = v11[i][31];
			mag11[i]    = 31'(v11[i][31] ? -v11[i] : v11[i]);
		end
		ds11.zero = norm11 == '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			norm_s11 <= norm11;
			ds_s11   <= ds11;
			for (int i = 0; i < 4; i++)
				num_s11[i] <= (NUM_W'(mag11[i]) << FRAC_BITS) + NUM_W'(norm11 >> 1);
		end
	end

	// divider chain: one quotient bit per cell
	logic [3:0][NUM_W-1:0] dr [QUO_W+1];
	logic [3:0][QUO_W-1:0] dq [QUO_W+1];
	logic [NORM_W-1:0]     dd [QUO_W+1];
	logic [DS_W-1:0]       dsd [QUO_W+1];

	assign dr[0]  = num_s11;
	assign dq[0]  = '0;
	assign dd[0]  = norm_s11;
	assign dsd[0] = ds_s11;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		qs_div_cell #(
			.NW(NUM_W), .DW(NORM_W), .QW(QUO_W), .K(QUO_W - 1 - k), .SW(DS_W)
		) u_cell (
			.clk    (clk),
			.en     (adv),
			.rem_i  (dr[k]),
			.q_i    (dq[k]),
			.den_i  (dd[k]),
			.side_i (dsd[k]),
			.rem_o  (dr[k+1]),
			.q_o    (dq[k+1]),
			.den_o  (dd[k+1]),
			.side_o (dsd[k+1])
		);
	end

	// output register: sign restore, saturate, identity on zero norm
	qs_div_side_t       dsf;
	logic signed [15:0] res [4];

	assign dsf = qs_div_side_t'(dsd[QUO_W]);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (dsf.zero)
				res[i] = (i == 0) ? sat16(17'sd1 <<< FRAC_BITS) : '0;
			else
				res[i] = sat16(dsf.neg[i] ? -17'(dq[QUO_W][i]) : 17'(dq[QUO_W][i]));
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && vld_q[L-1]) begin
			out_w <= res[0];
			out_x <= res[1];
			out_y <= res[2];
			out_z <= res[3];
		end
	end
endmodule

// ----- hw/rtl/qs_check.sv -----
// port-level checks for the slerp top, bound to every instance
module qs_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] out_w,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z
);
`include "quaternion_slerp_top_assert.svh"

	// a stalled result stays put
	`QS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_w)
		&& $stable(out_x) && $stable(out_y) && $stable(out_z), "stalled result changed")

	// the input side only backs up behind a held result
	`QS_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
		"input stalled without a held result")

	// normalized components never exceed one
	`QS_ASSERT_NOW(a_unit_wx, out_valid, out_w <= 16'sd16384 && out_w >= -16'sd16384
		&& out_x <= 16'sd16384 && out_x >= -16'sd16384, "w or x beyond unit range")
	`QS_ASSERT_NOW(a_unit_yz, out_valid, out_y <= 16'sd16384 && out_y >= -16'sd16384
		&& out_z <= 16'sd16384 && out_z >= -16'sd16384, "y or z beyond unit range")
endmodule

bind quaternion_slerp_top qs_check u_qs_check (.*);
